// ===== src/bft_pkg.sv =====
// Shared types and constants for the build file tokenizer.
package bft_pkg;

	localparam int LINE_W = 24;
	localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};

	// Configuration register indexes.
	localparam logic CFG_NEWLINE_SPECIAL = 1'b0;
	localparam logic CFG_START_LINE      = 1'b1;

	// Characters with a meaning of their own.
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// Token end codes.
	localparam logic [1:0] TE_NONE      = 2'd0;
	localparam logic [1:0] TE_DONE      = 2'd1;
	localparam logic [1:0] TE_ABANDONED = 2'd2;
	localparam logic [1:0] TE_EMPTY_QUO = 2'd3;

	// Error codes.
	localparam logic [1:0] ERR_NONE       = 2'd0;
	localparam logic [1:0] ERR_NL_IN_QUO  = 2'd1;
	localparam logic [1:0] ERR_WS_AFTER_Q = 2'd2;
	localparam logic [1:0] ERR_Q_IN_TOKEN = 2'd3;

	// Input item kinds.
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_EOI  = 1'b1;

	typedef struct packed {
		logic              char_valid;
		logic [7:0]        char_out;
		logic [1:0]        token_end;
		logic [1:0]        error_code;
		logic [LINE_W-1:0] line_no;
	} res_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_single(input logic [7:0] c);
		return (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_LBRACE) ||
			(c == CH_RBRACE) || (c == CH_COLON) || (c == CH_COMMA);
	endfunction

endpackage

// ===== src/build_file_tokenizer.sv =====
// Build file tokenizer: one character item in, one token result out.
// Throughput: one item per cycle while in_stall is low; the mode update is a
// single pass of logic. Each result is registered in the main or skid entry.
// A two-entry output buffer lets an item be taken while one result waits.
// Reset: mode between tokens, empty token, line counter at 1, no special newline.
// Writing start_line also loads the line counter.
module build_file_tokenizer
	import bft_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [LINE_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              kind,
	input  logic [7:0]        ch,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              char_valid,
	output logic [7:0]        char_out,
	output logic [1:0]        token_end,
	output logic [1:0]        error_code,
	output logic [LINE_W-1:0] line_no
);

	typedef enum logic [1:0] {
		MODE_BETWEEN,
		MODE_TOKEN,
		MODE_QUOTE,
		MODE_SKIP
	} mode_t;

	mode_t             mode_q, mode_d;
	logic              nonempty_q, nonempty_d;
	logic [LINE_W-1:0] line_q, line_d;
	logic              nl_special_q;
	logic              bump;
	res_t              res_d;
	res_t              out_q, skid_q;
	logic              out_valid_q, skid_valid_q;
	logic              accept, pop;

	assign accept = in_valid && !in_stall;
	assign pop    = out_valid_q && !out_stall;

	always_comb begin
		mode_d     = mode_q;
		nonempty_d = nonempty_q;
		bump       = 1'b0;
		res_d      = '0;
		if (kind == KIND_EOI) begin
			unique case (mode_q)
				MODE_TOKEN:   res_d.token_end = TE_DONE;
				MODE_QUOTE:   res_d.token_end = nonempty_q ? TE_DONE : TE_EMPTY_QUO;
				MODE_SKIP:    bump = 1'b1;
				MODE_BETWEEN: ;
				default:      ;
			endcase
			mode_d     = MODE_BETWEEN;
			nonempty_d = 1'b0;
		end else begin
			unique case (mode_q)
				MODE_BETWEEN: begin
					bump = (ch == CH_LF);
					priority if (is_single(ch) || (ch == CH_LF && nl_special_q)) begin
						res_d.char_valid = 1'b1;
						res_d.char_out   = ch;
						res_d.token_end  = TE_DONE;
					end else if (ch == CH_QUOTE) begin
						mode_d     = MODE_QUOTE;
						nonempty_d = 1'b0;
					end else if (is_ws(ch)) begin
					end else if (ch == CH_HASH || ch == CH_BSLASH) begin
						mode_d = MODE_SKIP;
					end else begin
						res_d.char_valid = 1'b1;
						res_d.char_out   = ch;
						mode_d           = MODE_TOKEN;
						nonempty_d       = 1'b1;
					end
				end
				MODE_TOKEN: begin
					priority if (is_ws(ch)) begin
						res_d.token_end = TE_DONE;
						if (ch == CH_LF) begin
							bump = 1'b1;
							if (nl_special_q) begin
								res_d.char_valid = 1'b1;
								res_d.char_out   = ch;
							end
						end
						mode_d     = MODE_BETWEEN;
						nonempty_d = 1'b0;
					end else if (ch == CH_QUOTE) begin
						res_d.error_code = ERR_Q_IN_TOKEN;
						res_d.token_end  = TE_ABANDONED;
						mode_d           = MODE_BETWEEN;
						nonempty_d       = 1'b0;
					end else begin
						res_d.char_valid = 1'b1;
						res_d.char_out   = ch;
					end
				end
				MODE_QUOTE: begin
					priority if (ch == CH_QUOTE) begin
						res_d.token_end = nonempty_q ? TE_DONE : TE_EMPTY_QUO;
						mode_d          = MODE_BETWEEN;
						nonempty_d      = 1'b0;
					end else if (ch == CH_LF) begin
						res_d.error_code = ERR_NL_IN_QUO;
						res_d.token_end  = TE_ABANDONED;
						mode_d           = MODE_BETWEEN;
						nonempty_d       = 1'b0;
					end else if (!nonempty_q && is_ws(ch)) begin
						res_d.error_code = ERR_WS_AFTER_Q;
					end else begin
						res_d.char_valid = 1'b1;
						res_d.char_out   = ch;
						nonempty_d       = 1'b1;
					end
				end
				MODE_SKIP: begin
					if (ch == CH_LF) begin
						bump   = 1'b1;
						mode_d = MODE_BETWEEN;
					end
				end
				default: ;
			endcase
		end
		line_d = (bump && line_q != LINE_MAX) ? line_q + 1'b1 : line_q;
		res_d.line_no = line_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_BETWEEN;
			nonempty_q   <= 1'b0;
			line_q       <= LINE_W'(1);
			nl_special_q <= 1'b0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_NEWLINE_SPECIAL: nl_special_q <= cfg_data[0];
					CFG_START_LINE:      line_q       <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				mode_q     <= mode_d;
				nonempty_q <= nonempty_d;
				line_q     <= line_d;
			end
			// The skid entry holds a result only while the main entry is stalled.
			if (skid_valid_q) begin
				if (pop) begin
					out_q        <= skid_q;
					skid_valid_q <= 1'b0;
				end
			end else if (accept) begin
				if (out_valid_q && !pop) begin
					skid_q       <= res_d;
					skid_valid_q <= 1'b1;
				end else begin
					out_q       <= res_d;
					out_valid_q <= 1'b1;
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall    = skid_valid_q;
	assign out_valid   = out_valid_q;
	assign char_valid  = out_q.char_valid;
	assign char_out    = out_q.char_out;
	assign token_end   = out_q.token_end;
	assign error_code  = out_q.error_code;
	assign line_no     = out_q.line_no;

`ifndef ASSERT_OFF
	a_skid_needs_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds a result while the main entry is empty");

	a_token_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_TOKEN) |-> nonempty_q)
		else $error("token mode with an empty token");

	a_between_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_BETWEEN || mode_q == MODE_SKIP) |-> !nonempty_q)
		else $error("token marked non-empty outside a token");

	a_err_abandons: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.error_code == ERR_NL_IN_QUO ||
			out_q.error_code == ERR_Q_IN_TOKEN)) |-> (out_q.token_end == TE_ABANDONED))
		else $error("error result does not abandon the token");

	a_line_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_we |=> (line_q >= $past(line_q)))
		else $error("line counter went backward without a configuration write");
`endif

endmodule

// ===== tb/build_file_tokenizer_checker.sv =====
// Checker for the build file tokenizer: predicts each result and compares it.
module build_file_tokenizer_checker
	import bft_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [LINE_W-1:0] cfg_data,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              kind,
	input  logic [7:0]        ch,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic              char_valid,
	input  logic [7:0]        char_out,
	input  logic [1:0]        token_end,
	input  logic [1:0]        error_code,
	input  logic [LINE_W-1:0] line_no,
	output int                mismatches,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;

	typedef enum logic [1:0] {
		LEX_BETWEEN,
		LEX_TOKEN,
		LEX_QUOTE,
		LEX_SKIP
	} lex_mode_e;

	lex_mode_e         lex_mode;
	logic              has_chars;
	logic [LINE_W-1:0] line_cnt;
	logic              nl_token;
	res_t              token_results_q[$];
	int                mismatch_total;

	function automatic logic is_blank(input logic [7:0] c);
		case (c)
			CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [LINE_W-1:0] next_line(input logic [LINE_W-1:0] l);
		return (l == LINE_MAX) ? l : l + 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		res_t want;
		res_t got;
		res_t exp;
		logic punct;

		if (!arst_n) begin
			lex_mode = LEX_BETWEEN;
			has_chars = 1'b0;
			line_cnt = LINE_W'(1);
			nl_token = 1'b0;
			token_results_q.delete();
			mismatch_total = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			// Register writes only happen while nothing is in flight.
			if (cfg_we) begin
				if (cfg_index == CFG_NEWLINE_SPECIAL)
					nl_token = cfg_data[0];
				else
					line_cnt = cfg_data;
			end

			if (out_valid && !out_stall) begin
				got = {char_valid, char_out, token_end, error_code, line_no};
				if (token_results_q.size() == 0) begin
					if (mismatch_total < 10)
						$display("unexpected result cv=%0d co=%02h te=%0d ec=%0d ln=%0d",
							char_valid, char_out, token_end, error_code, line_no);
					mismatch_total++;
				end else begin
					want = token_results_q.pop_front();
					if (got !== want) begin
						if (mismatch_total < 10)
							$display("mismatch: exp %0d %02h %0d %0d %0d got %0d %02h %0d %0d %0d",
								want.char_valid, want.char_out, want.token_end,
								want.error_code, want.line_no, got.char_valid,
								got.char_out, got.token_end, got.error_code,
								got.line_no);
						mismatch_total++;
					end
				end
			end

			if (in_valid && !in_stall) begin
				exp = '0;
				punct = (ch == CH_LPAREN) || (ch == CH_RPAREN) || (ch == CH_LBRACE) ||
					(ch == CH_RBRACE) || (ch == CH_COLON) || (ch == CH_COMMA);
				if (kind == KIND_EOI) begin
					case (lex_mode)
						LEX_TOKEN: exp.token_end = TE_DONE;
						LEX_QUOTE: exp.token_end = has_chars ? TE_DONE : TE_EMPTY_QUO;
						LEX_SKIP:  line_cnt = next_line(line_cnt);
						default: ;
					endcase
					lex_mode = LEX_BETWEEN;
					has_chars = 1'b0;
				end else begin
					case (lex_mode)
						LEX_BETWEEN: begin
							if (ch == CH_LF)
								line_cnt = next_line(line_cnt);
							if (punct || (ch == CH_LF && nl_token)) begin
								exp.char_valid = 1'b1;
								exp.char_out = ch;
								exp.token_end = TE_DONE;
							end else if (ch == CH_QUOTE) begin
								lex_mode = LEX_QUOTE;
								has_chars = 1'b0;
							end else if (ch == CH_HASH || ch == CH_BSLASH) begin
								lex_mode = LEX_SKIP;
							end else if (!is_blank(ch)) begin
								exp.char_valid = 1'b1;
								exp.char_out = ch;
								lex_mode = LEX_TOKEN;
								has_chars = 1'b1;
							end
						end
						LEX_TOKEN: begin
							if (is_blank(ch)) begin
								exp.token_end = TE_DONE;
								// A newline closes the token and may be a token itself.
								if (ch == CH_LF) begin
									line_cnt = next_line(line_cnt);
									if (nl_token) begin
										exp.char_valid = 1'b1;
										exp.char_out = ch;
									end
								end
								lex_mode = LEX_BETWEEN;
								has_chars = 1'b0;
							end else if (ch == CH_QUOTE) begin
								exp.error_code = ERR_Q_IN_TOKEN;
								exp.token_end = TE_ABANDONED;
								lex_mode = LEX_BETWEEN;
								has_chars = 1'b0;
							end else begin
								exp.char_valid = 1'b1;
								exp.char_out = ch;
							end
						end
						LEX_QUOTE: begin
							if (ch == CH_QUOTE) begin
								exp.token_end = has_chars ? TE_DONE : TE_EMPTY_QUO;
								lex_mode = LEX_BETWEEN;
								has_chars = 1'b0;
							end else if (ch == CH_LF) begin
								exp.error_code = ERR_NL_IN_QUO;
								exp.token_end = TE_ABANDONED;
								lex_mode = LEX_BETWEEN;
								has_chars = 1'b0;
							end else if (!has_chars && is_blank(ch)) begin
								exp.error_code = ERR_WS_AFTER_Q;
							end else begin
								exp.char_valid = 1'b1;
								exp.char_out = ch;
								has_chars = 1'b1;
							end
						end
						default: begin
							if (ch == CH_LF) begin
								line_cnt = next_line(line_cnt);
								lex_mode = LEX_BETWEEN;
							end
						end
					endcase
				end
				exp.line_no = line_cnt;
				token_results_q.push_back(exp);
			end

			mismatches <= mismatch_total;
			pending <= token_results_q.size();
		end
	end

endmodule

// ===== tb/build_file_tokenizer_test.sv =====
// Testbench top for the build file tokenizer: stimulus, handshakes and verdict.
module build_file_tokenizer_test;
	import bft_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         CYCLE_LIMIT  = 200000;
	localparam int         HOLD_CYCLES  = 60;
	localparam int         SEG_ITEMS    = 240;
	localparam int         SEGMENTS     = 6;
	localparam logic [7:0] CH_VT        = 8'h0B;
	localparam logic [7:0] CH_FF        = 8'h0C;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_index;
	logic [LINE_W-1:0] cfg_data;
	logic              in_valid;
	logic              in_stall;
	logic              kind;
	logic [7:0]        ch;
	logic              out_valid;
	logic              out_stall;
	logic              char_valid;
	logic [7:0]        char_out;
	logic [1:0]        token_end;
	logic [1:0]        error_code;
	logic [LINE_W-1:0] line_no;

	int   mismatches;
	int   pending;
	int   in_idle_pct;
	int   out_idle_pct;
	int   items_sent;
	int   cycles;
	logic hold_go;
	logic hold_on;

	build_file_tokenizer u_dut (.*);

	build_file_tokenizer_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk)
		out_stall <= hold_on || ($urandom_range(99) < out_idle_pct);

	// One long receiver hold-off so the output buffer fills and the input stalls.
	initial begin
		hold_on = 1'b0;
		do @(posedge clk); while (!hold_go);
		hold_on <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on <= 1'b0;
	end

	task automatic send_item(input logic k, input logic [7:0] c);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		ch <= c;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic write_reg(input logic idx, input logic [LINE_W-1:0] data);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] word_char();
		case ($urandom_range(3))
			0: return 8'h61 + 8'($urandom_range(25));
			1: return 8'h30 + 8'($urandom_range(9));
			2: return 8'h80 + 8'($urandom_range(127));
			default: return 8'h21 + 8'($urandom_range(93));
		endcase
	endfunction

	function automatic logic [7:0] blank_char();
		case ($urandom_range(5))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_LF;
			3: return CH_VT;
			4: return CH_FF;
			default: return CH_CR;
		endcase
	endfunction

	function automatic logic [7:0] punct_char();
		case ($urandom_range(5))
			0: return CH_LPAREN;
			1: return CH_RPAREN;
			2: return CH_LBRACE;
			3: return CH_RBRACE;
			4: return CH_COLON;
			default: return CH_COMMA;
		endcase
	endfunction

	// Mostly well-formed pieces of a build file, with some noise mixed in.
	task automatic send_fragment();
		int n;
		int pick;

		pick = $urandom_range(19);
		case (pick)
			0, 1, 2, 3, 4, 5: begin
				n = $urandom_range(1, 8);
				repeat (n) send_item(KIND_CHAR, word_char());
			end
			6, 7, 8: begin
				send_item(KIND_CHAR, CH_QUOTE);
				if ($urandom_range(3) == 0)
					send_item(KIND_CHAR, blank_char());
				n = $urandom_range(0, 6);
				repeat (n)
					send_item(KIND_CHAR, ($urandom_range(4) == 0) ? CH_SPACE : word_char());
				send_item(KIND_CHAR, ($urandom_range(9) == 0) ? CH_LF : CH_QUOTE);
			end
			9, 10: send_item(KIND_CHAR, punct_char());
			11, 12, 13: send_item(KIND_CHAR, blank_char());
			14: send_item(KIND_CHAR, CH_LF);
			15: begin
				send_item(KIND_CHAR, $urandom_range(1) ? CH_HASH : CH_BSLASH);
				n = $urandom_range(0, 6);
				repeat (n) send_item(KIND_CHAR, 8'($urandom_range(255)));
				send_item(KIND_CHAR, CH_LF);
			end
			16: send_item(KIND_CHAR, 8'($urandom_range(255)));
			17: begin
				send_item(KIND_CHAR, word_char());
				send_item(KIND_CHAR, CH_QUOTE);
			end
			18: send_item(KIND_EOI, 8'($urandom_range(255)));
			default: begin
				case ($urandom_range(3))
					0: send_item(KIND_CHAR, CH_QUOTE);
					1: send_item(KIND_CHAR, CH_HASH);
					2: send_item(KIND_CHAR, CH_BSLASH);
					default: send_item(KIND_CHAR, punct_char());
				endcase
			end
		endcase
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_NEWLINE_SPECIAL;
		cfg_data <= '0;
		in_valid <= 1'b0;
		kind <= KIND_CHAR;
		ch <= '0;
		hold_go <= 1'b0;
		items_sent = 0;
		in_idle_pct = 31;
		out_idle_pct = 79;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: special newline and a line counter about to saturate.
		write_reg(CFG_NEWLINE_SPECIAL, LINE_W'(1));
		write_reg(CFG_START_LINE, LINE_MAX - LINE_W'(1));
		send_item(KIND_CHAR, CH_LPAREN);
		send_item(KIND_CHAR, "a");
		send_item(KIND_CHAR, CH_LF);
		send_item(KIND_CHAR, CH_QUOTE);
		send_item(KIND_CHAR, CH_QUOTE);
		send_item(KIND_CHAR, CH_QUOTE);
		send_item(KIND_CHAR, CH_SPACE);
		send_item(KIND_CHAR, "x");
		send_item(KIND_CHAR, CH_LF);
		send_item(KIND_CHAR, "b");
		send_item(KIND_CHAR, CH_QUOTE);
		send_item(KIND_CHAR, CH_HASH);
		send_item(KIND_CHAR, "z");
		send_item(KIND_CHAR, CH_LF);
		send_item(KIND_CHAR, CH_BSLASH);
		send_item(KIND_CHAR, CH_LF);
		send_item(KIND_CHAR, 8'hFF);
		send_item(KIND_CHAR, 8'h00);
		send_item(KIND_CHAR, CH_COLON);
		send_item(KIND_EOI, 8'h00);
		send_item(KIND_CHAR, CH_QUOTE);
		send_item(KIND_EOI, 8'hFF);
		send_item(KIND_CHAR, CH_QUOTE);
		send_item(KIND_CHAR, "q");
		send_item(KIND_EOI, 8'h5A);
		send_item(KIND_CHAR, CH_HASH);
		send_item(KIND_EOI, 8'hA5);
		send_item(KIND_CHAR, CH_LF);

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg)
				0: begin
					write_reg(CFG_NEWLINE_SPECIAL, '0);
					write_reg(CFG_START_LINE, '0);
				end
				1: begin
					write_reg(CFG_NEWLINE_SPECIAL, LINE_W'(1));
					write_reg(CFG_START_LINE, LINE_W'($urandom));
				end
				2: begin
					write_reg(CFG_NEWLINE_SPECIAL, '0);
					write_reg(CFG_START_LINE, LINE_MAX - LINE_W'(3));
				end
				3: begin
					write_reg(CFG_NEWLINE_SPECIAL, LINE_W'(1));
					write_reg(CFG_START_LINE, LINE_MAX);
				end
				4: begin
					write_reg(CFG_NEWLINE_SPECIAL, LINE_W'($urandom_range(1)));
					write_reg(CFG_START_LINE, LINE_W'($urandom));
				end
				default: begin
					write_reg(CFG_NEWLINE_SPECIAL, LINE_W'(1));
					write_reg(CFG_START_LINE, LINE_W'(1));
				end
			endcase
			if (seg < 2) begin
				in_idle_pct = 31;
				out_idle_pct = 79;
			end else if (seg < 4) begin
				in_idle_pct = 79;
				out_idle_pct = 31;
			end else begin
				in_idle_pct = 0;
				out_idle_pct = 0;
			end
			if (seg == 0)
				hold_go <= 1'b1;
			while (items_sent < 28 + (seg + 1) * SEG_ITEMS)
				send_fragment();
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
src/bft_pkg.sv
src/build_file_tokenizer.sv
tb/build_file_tokenizer_checker.sv
tb/build_file_tokenizer_test.sv
